/* design/ster_pkg.sv */
// Shared types, constants and register indexes for the SEI tagged record extractor.
package ster_pkg;

    localparam int MAX_RECORD_BYTES = 4096;
    localparam int MAX_WINDOW_BYTES = 1024;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int LEN_W = 13;
    localparam int WIN_W = 10;
    localparam int WIN_CNT_W = 11;
    localparam int OFF_W = 12;
    localparam int NUM_W = 16;
    localparam int QUEUE_DEPTH = 8;

    localparam logic [CFG_IDX_W-1:0] REG_RECORD_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_WINDOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_PATTERN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAG_PATTERN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VALID_RATE_MASK = 3'd4;

    localparam logic [LEN_W-1:0] RST_RECORD_LENGTH = 13'd2048;
    localparam logic [WIN_W-1:0] RST_SEARCH_WINDOW = 10'd200;
    localparam logic [31:0] RST_START_PATTERN = 32'h0001_0625;
    localparam logic [31:0] RST_TAG_PATTERN = 32'h4F46_4D44;
    localparam logic [15:0] RST_VALID_RATE_MASK = 16'h00DE;

    localparam logic [LEN_W-1:0] MIN_LEN = 13'd5;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_RECORD_BYTES);
    localparam logic [NUM_W-1:0] NUM_MAX = 16'hFFFF;

    // One queued request from the front part: a single record byte, or a record start
    // that expands into the four tag bytes followed by the rate byte.
    typedef struct packed {
        logic             is_start;
        logic [31:0]      tag;
        logic [7:0]       data;
        logic [OFF_W-1:0] offset;
        logic             last;
        logic             trunc;
        logic [NUM_W-1:0] num;
    } t_cmd;

endpackage

/* design/sei_tagged_record_extractor.sv */
// Top level of the SEI tagged record extractor: front scanner, request queue and output expander.
// The input channel takes one stream byte per request (i_stream_byte, with i_stream_end on the
// final byte of a stream) under i_in_valid / o_in_ready. The output channel delivers one record
// byte per request under o_out_valid / i_out_ready, with its offset in the record, last and
// truncated flags, and the record number. Configuration is written through i_cfg_we, i_cfg_idx
// and i_cfg_data while the block is idle; the user must keep to this. The block itself does
// not enforce it. Throughput is one stream byte per cycle while the queue is not full. The
// scanner handles each byte in the cycle it is accepted and queues at most one request; a record
// start becomes five result items (four tag bytes and the rate byte) that the back part sends,
// and an eight-entry queue absorbs the four extra items so a long record keeps streaming at one
// byte per cycle while the receiver is ready. A result passes through the queue and the output
// register. If the receiver stalls, results wait in the output register and the queue; o_in_ready
// drops only when the queue is full. Reset is synchronous and active low; it restores all
// configuration registers to their defaults, returns the scanner to hunting for the start
// pattern, clears the record counter and empties the queue and output register.
module sei_tagged_record_extractor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ster_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ster_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_stream_byte,
    input  logic                           i_stream_end,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [7:0]                     o_record_byte,
    output logic [ster_pkg::OFF_W-1:0]     o_byte_offset,
    output logic                           o_last_of_record,
    output logic                           o_truncated,
    output logic [ster_pkg::NUM_W-1:0]     o_record_number
);
    import ster_pkg::*;

    logic accept, push, full, pop, q_valid;
    t_cmd push_cmd, q_cmd;

    assign o_in_ready = !full;
    assign accept     = i_in_valid && !full;

    ster_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_stream_byte (i_stream_byte),
        .i_stream_end  (i_stream_end),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    ster_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    ster_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_cmd          (q_cmd),
        .o_pop            (pop),
        .o_valid          (o_out_valid),
        .i_ready          (i_out_ready),
        .o_record_byte    (o_record_byte),
        .o_byte_offset    (o_byte_offset),
        .o_last_of_record (o_last_of_record),
        .o_truncated      (o_truncated),
        .o_record_number  (o_record_number)
    );

endmodule

/* design/ster_front.sv */
// Front part: configuration registers, start and tag hunting, and capture control.
module ster_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ster_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ster_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_accept,
    input  logic [7:0]                     i_stream_byte,
    input  logic                           i_stream_end,
    output logic                           o_push,
    output ster_pkg::t_cmd                 o_cmd
);
    import ster_pkg::*;

    localparam logic [1:0] MODE_HUNT = 2'd0;
    localparam logic [1:0] MODE_TAG  = 2'd1;
    localparam logic [1:0] MODE_RATE = 2'd2;

    logic [LEN_W-1:0] r_rec_len;
    logic [WIN_W-1:0] r_win;
    logic [31:0]      r_start_pat;
    logic [31:0]      r_tag_pat;
    logic [15:0]      r_mask;

    logic [1:0]           r_mode, n_mode;
    logic [23:0]          r_start_hist, n_start_hist;
    logic [31:0]          r_tag_hist, n_tag_hist;
    logic [WIN_CNT_W-1:0] r_win_cnt, n_win_cnt;
    logic [OFF_W-1:0]     r_cap, n_cap;
    logic [NUM_W-1:0]     r_acc, n_acc;
    logic [NUM_W-1:0]     r_cur, n_cur;

    logic [LEN_W-1:0]     len;
    logic [31:0]          hunt_word;
    logic [31:0]          et_tag;
    logic [WIN_CNT_W-1:0] et_win;
    logic                 run_eval;
    logic [LEN_W-1:0]     cap_next;
    logic                 cap_nat, cap_last, start_nat, start_last, rate_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_len   <= RST_RECORD_LENGTH;
            r_win       <= RST_SEARCH_WINDOW;
            r_start_pat <= RST_START_PATTERN;
            r_tag_pat   <= RST_TAG_PATTERN;
            r_mask      <= RST_VALID_RATE_MASK;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RECORD_LENGTH:   r_rec_len   <= i_cfg_data[LEN_W-1:0];
                REG_SEARCH_WINDOW:   r_win       <= i_cfg_data[WIN_W-1:0];
                REG_START_PATTERN:   r_start_pat <= i_cfg_data[31:0];
                REG_TAG_PATTERN:     r_tag_pat   <= i_cfg_data[31:0];
                REG_VALID_RATE_MASK: r_mask      <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_rec_len < MIN_LEN) begin
            len = MIN_LEN;
        end else if (r_rec_len > MAX_LEN) begin
            len = MAX_LEN;
        end else begin
            len = r_rec_len;
        end

        n_mode       = r_mode;
        n_start_hist = r_start_hist;
        n_tag_hist   = r_tag_hist;
        n_win_cnt    = r_win_cnt;
        n_cap        = r_cap;
        n_acc        = r_acc;
        n_cur        = r_cur;
        o_push       = 1'b0;
        o_cmd        = '0;

        cap_next   = {1'b0, r_cap} + 13'd1;
        cap_nat    = cap_next >= len;
        cap_last   = cap_nat || i_stream_end;
        start_nat  = len <= MIN_LEN;
        start_last = start_nat || i_stream_end;
        rate_ok    = r_mask[i_stream_byte[3:0]];

        if (r_cap != '0) begin
            o_push       = 1'b1;
            o_cmd.data   = i_stream_byte;
            o_cmd.offset = r_cap;
            o_cmd.last   = cap_last;
            o_cmd.trunc  = i_stream_end && !cap_nat;
            o_cmd.num    = r_cur;
            n_cap        = cap_last ? '0 : cap_next[OFF_W-1:0];
        end

        if (r_mode == MODE_RATE && rate_ok) begin
            o_push         = 1'b1;
            o_cmd.is_start = 1'b1;
            o_cmd.tag      = r_tag_hist;
            o_cmd.data     = i_stream_byte;
            o_cmd.offset   = OFF_W'(4);
            o_cmd.last     = start_last;
            o_cmd.trunc    = i_stream_end && !start_nat;
            o_cmd.num      = r_acc;
            n_cur          = r_acc;
            if (r_acc != NUM_MAX) begin
                n_acc = r_acc + 16'd1;
            end
            n_cap = start_last ? '0 : OFF_W'(5);
        end

        hunt_word = {r_start_hist, i_stream_byte};
        if (r_mode == MODE_TAG) begin
            et_tag   = {r_tag_hist[23:0], i_stream_byte};
            et_win   = r_win_cnt + 11'd1;
            run_eval = 1'b1;
        end else begin
            et_tag   = hunt_word;
            et_win   = WIN_CNT_W'(4);
            run_eval = hunt_word == r_start_pat;
            n_mode   = MODE_HUNT;
            if (!run_eval) begin
                n_start_hist = hunt_word[23:0];
            end
        end

        if (run_eval) begin
            n_tag_hist = et_tag;
            n_win_cnt  = et_win;
            if (et_tag == r_tag_pat && et_win <= {1'b0, r_win}) begin
                n_start_hist = et_tag[23:0];
                n_mode       = (n_cap != '0) ? MODE_HUNT : MODE_RATE;
            end else if (et_win >= {1'b0, r_win}) begin
                n_mode       = MODE_HUNT;
                n_start_hist = '1;
            end else begin
                n_mode = MODE_TAG;
            end
        end

        if (i_stream_end) begin
            n_mode       = MODE_HUNT;
            n_start_hist = '1;
            n_tag_hist   = '1;
            n_win_cnt    = '0;
            n_cap        = '0;
        end

        if (!i_accept) begin
            o_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_HUNT;
            r_start_hist <= '1;
            r_tag_hist   <= '1;
            r_win_cnt    <= '0;
            r_cap        <= '0;
            r_acc        <= '0;
            r_cur        <= '0;
        end else if (i_accept) begin
            r_mode       <= n_mode;
            r_start_hist <= n_start_hist;
            r_tag_hist   <= n_tag_hist;
            r_win_cnt    <= n_win_cnt;
            r_cap        <= n_cap;
            r_acc        <= n_acc;
            r_cur        <= n_cur;
        end
    end

endmodule

/* design/ster_queue.sv */
// Short request queue between the front and back parts.
module ster_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ster_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output ster_pkg::t_cmd o_cmd
);
    import ster_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = r_cnt == CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

/* design/ster_back.sv */
// Back part: expands queued requests into result items on the output channel.
module ster_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  ster_pkg::t_cmd             i_q_cmd,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [7:0]                 o_record_byte,
    output logic [ster_pkg::OFF_W-1:0] o_byte_offset,
    output logic                       o_last_of_record,
    output logic                       o_truncated,
    output logic [ster_pkg::NUM_W-1:0] o_record_number
);
    import ster_pkg::*;

    logic       r_busy;
    t_cmd       r_cmd;
    logic [2:0] r_phase;
    logic       fire, finishing, rate_phase;

    assign rate_phase = !r_cmd.is_start || r_phase == 3'd4;
    assign fire       = r_busy && i_ready;
    assign finishing  = rate_phase;
    assign o_pop      = i_q_valid && (!r_busy || (fire && finishing));
    assign o_valid    = r_busy;

    always_comb begin
        case (r_phase)
            3'd0:    o_record_byte = r_cmd.is_start ? r_cmd.tag[31:24] : r_cmd.data;
            3'd1:    o_record_byte = r_cmd.tag[23:16];
            3'd2:    o_record_byte = r_cmd.tag[15:8];
            3'd3:    o_record_byte = r_cmd.tag[7:0];
            default: o_record_byte = r_cmd.data;
        endcase
        o_byte_offset    = r_cmd.is_start ? OFF_W'(r_phase) : r_cmd.offset;
        o_last_of_record = rate_phase && r_cmd.last;
        o_truncated      = rate_phase && r_cmd.trunc;
        o_record_number  = r_cmd.num;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= '0;
        end else if (o_pop) begin
            r_busy  <= 1'b1;
            r_phase <= '0;
        end else if (fire) begin
            if (finishing) begin
                r_busy <= 1'b0;
            end else begin
                r_phase <= r_phase + 3'd1;
            end
        end
    end

endmodule

/* tb/sei_tagged_record_extractor_test.sv */
// Self-checking testbench for the SEI tagged record extractor with a built-in record predictor.
module sei_tagged_record_extractor_test;
    import ster_pkg::*;

    localparam int RESET_CYCLES = 9;
    localparam int MAX_GAP = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT = 10;

    typedef enum logic [1:0] {
        SCAN_START,
        SCAN_TAG,
        SCAN_RATE
    } t_scan_state;

    typedef struct packed {
        logic [7:0]       data;
        logic [OFF_W-1:0] offset;
        logic             last;
        logic             trunc;
        logic [NUM_W-1:0] number;
    } t_record_byte;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [7:0]            i_stream_byte;
    logic                  i_stream_end;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [7:0]            o_record_byte;
    logic [OFF_W-1:0]      o_byte_offset;
    logic                  o_last_of_record;
    logic                  o_truncated;
    logic [NUM_W-1:0]      o_record_number;

    sei_tagged_record_extractor uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_stream_byte    (i_stream_byte),
        .i_stream_end     (i_stream_end),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_record_byte    (o_record_byte),
        .o_byte_offset    (o_byte_offset),
        .o_last_of_record (o_last_of_record),
        .o_truncated      (o_truncated),
        .o_record_number  (o_record_number)
    );

    // Predictor configuration and scan state.
    logic [LEN_W-1:0] cfg_len;
    logic [WIN_W-1:0] cfg_win;
    logic [31:0]      cfg_start;
    logic [31:0]      cfg_tag;
    logic [15:0]      cfg_rates;
    t_scan_state      scan_state;
    logic [23:0]      start_shift;
    logic [31:0]      tag_shift;
    int               window_count;
    int               capture_pos;
    logic [NUM_W-1:0] records_seen;
    logic [NUM_W-1:0] capture_number;

    t_record_byte expected_bytes[$];
    int           fault_count = 0;
    int           sent_items = 0;
    int           stall_cycles = 0;
    bit           sender_calm = 1'b0;
    bit           sink_calm = 1'b0;
    bit           hold_request = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int effective_length();
        if (cfg_len < MIN_LEN) return int'(MIN_LEN);
        if (cfg_len > MAX_RECORD_BYTES) return MAX_RECORD_BYTES;
        return int'(cfg_len);
    endfunction

    function automatic int effective_window();
        if (cfg_win > MAX_WINDOW_BYTES) return MAX_WINDOW_BYTES;
        return int'(cfg_win);
    endfunction

    function automatic void clear_scan();
        scan_state = SCAN_START;
        start_shift = '1;
        tag_shift = '1;
        window_count = 0;
        capture_pos = 0;
    endfunction

    function automatic void reset_prediction();
        cfg_len = RST_RECORD_LENGTH;
        cfg_win = RST_SEARCH_WINDOW;
        cfg_start = RST_START_PATTERN;
        cfg_tag = RST_TAG_PATTERN;
        cfg_rates = RST_VALID_RATE_MASK;
        clear_scan();
        records_seen = '0;
        capture_number = '0;
    endfunction

    function automatic void push_expected(input logic [7:0] data, input int off,
                                          input bit last, input bit trunc,
                                          input logic [NUM_W-1:0] number);
        t_record_byte item;
        item.data = data;
        item.offset = off[OFF_W-1:0];
        item.last = last;
        item.trunc = trunc;
        item.number = number;
        expected_bytes.push_back(item);
    endfunction

    function automatic void check_tag();
        int w;
        w = effective_window();
        if (tag_shift == cfg_tag && window_count <= w) begin
            start_shift = tag_shift[23:0];
            scan_state = (capture_pos != 0) ? SCAN_START : SCAN_RATE;
        end else if (window_count >= w) begin
            scan_state = SCAN_START;
            start_shift = '1;
        end else begin
            scan_state = SCAN_TAG;
        end
    endfunction

    function automatic void hunt_start(input logic [7:0] b);
        logic [31:0] word;
        word = {start_shift, b};
        if (word == cfg_start) begin
            tag_shift = word;
            window_count = 4;
            check_tag();
        end else begin
            start_shift = word[23:0];
        end
    endfunction

    function automatic void predict_stream_byte(input logic [7:0] b, input bit stream_done);
        int len;
        int off;
        int k;
        bit nat;
        bit fin;
        len = effective_length();
        if (capture_pos != 0) begin
            off = capture_pos;
            nat = (off + 1 >= len);
            fin = nat || stream_done;
            push_expected(b, off, fin, stream_done && !nat, capture_number);
            capture_pos = fin ? 0 : off + 1;
        end
        case (scan_state)
            SCAN_RATE: begin
                if (cfg_rates[b[3:0]]) begin
                    nat = (len <= 5);
                    fin = nat || stream_done;
                    capture_number = records_seen;
                    if (records_seen != NUM_MAX) records_seen++;
                    for (k = 0; k < 4; k++)
                        push_expected(tag_shift[31-8*k -: 8], k, 1'b0, 1'b0, capture_number);
                    push_expected(b, 4, fin, stream_done && !nat, capture_number);
                    capture_pos = fin ? 0 : 5;
                end
                scan_state = SCAN_START;
                hunt_start(b);
            end
            SCAN_TAG: begin
                tag_shift = {tag_shift[23:0], b};
                if (window_count < 'hFFFF) window_count++;
                check_tag();
            end
            default: begin
                scan_state = SCAN_START;
                hunt_start(b);
            end
        endcase
        if (stream_done) clear_scan();
    endfunction

    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 31) == 0) calm = !calm;
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit stream_done);
        int gap;
        gap = draw_gap(sender_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_stream_byte <= b;
        i_stream_end <= stream_done;
        do @(posedge i_clk); while (!o_in_ready);
        predict_stream_byte(b, stream_done);
        sent_items++;
        @(negedge i_clk);
    endtask

    task automatic send_word(input logic [31:0] word, input bit end_on_last);
        int k;
        for (k = 0; k < 4; k++)
            send_byte(word[31-8*k -: 8], end_on_last && k == 3);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_RECORD_LENGTH:   cfg_len = data[LEN_W-1:0];
            REG_SEARCH_WINDOW:   cfg_win = data[WIN_W-1:0];
            REG_START_PATTERN:   cfg_start = data;
            REG_TAG_PATTERN:     cfg_tag = data;
            REG_VALID_RATE_MASK: cfg_rates = data[15:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [31:0] len, input logic [31:0] win,
                              input logic [31:0] start, input logic [31:0] tag,
                              input logic [31:0] rates);
        settle();
        write_register(REG_RECORD_LENGTH, len);
        write_register(REG_SEARCH_WINDOW, win);
        write_register(REG_START_PATTERN, start);
        write_register(REG_TAG_PATTERN, tag);
        write_register(REG_VALID_RATE_MASK, rates);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // A start, then noise or an optional tag in or just past the window, a rate byte, a tail.
    task automatic send_record_attempt();
        logic [7:0] seq[$];
        logic [7:0] rate;
        int len;
        int win;
        int fill_max;
        int filler;
        int tail;
        int end_at;
        int k;
        len = effective_length();
        win = effective_window();
        repeat ($urandom_range(0, 2)) seq.push_back(8'($urandom));
        for (k = 0; k < 4; k++) seq.push_back(cfg_start[31-8*k -: 8]);
        fill_max = (win > 8) ? win - 8 + 1 : 0;
        if (fill_max > 24) fill_max = 24;
        filler = $urandom_range(0, fill_max);
        if ($urandom_range(0, 5) == 0) begin
            repeat (filler + 3) seq.push_back(8'($urandom));
        end else begin
            if (cfg_tag != cfg_start || $urandom_range(0, 1) == 1) begin
                repeat (filler) seq.push_back(8'($urandom));
                for (k = 0; k < 4; k++) seq.push_back(cfg_tag[31-8*k -: 8]);
            end
            rate = 8'($urandom);
            if (cfg_rates != '0 && $urandom_range(0, 4) != 0)
                while (!cfg_rates[rate[3:0]]) rate[3:0] = 4'($urandom);
            seq.push_back(rate);
            tail = $urandom_range(0, (len > 40) ? 40 : len - 3);
            repeat (tail) seq.push_back(8'($urandom));
        end
        end_at = -1;
        if ($urandom_range(0, (len > 40) ? 1 : 7) == 0)
            end_at = $urandom_range(0, seq.size() - 1);
        for (k = 0; k < seq.size(); k++) send_byte(seq[k], k == end_at);
    endtask

    task automatic run_random(input int count);
        int target;
        target = sent_items + count;
        while (sent_items < target) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom), $urandom_range(0, 15) == 0);
            end else begin
                send_record_attempt();
            end
        end
    endtask

    task automatic test_reset_defaults();
        send_word(RST_START_PATTERN, 1'b0);
        send_word(RST_TAG_PATTERN, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7E, 1'b1);
        send_word(RST_START_PATTERN, 1'b0);
        send_word(RST_TAG_PATTERN, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_word(RST_START_PATTERN, 1'b0);
        send_word(RST_TAG_PATTERN, 1'b1);
    endtask

    task automatic test_short_records();
        set_config(12, 40, RST_START_PATTERN, RST_TAG_PATTERN, 32'(RST_VALID_RATE_MASK));
        run_random(60);
    endtask

    task automatic test_minimum_window();
        logic [31:0] start;
        start = $urandom;
        set_config(0, 8, start, {start[15:0], 16'($urandom)}, 32'hFFFF);
        run_random(45);
    endtask

    task automatic test_all_ones_start();
        set_config(30, 1023, 32'hFFFF_FFFF, $urandom, 32'hA5A5);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        run_random(40);
    endtask

    task automatic test_rate_rejection();
        set_config(5, 32'(RST_SEARCH_WINDOW), RST_START_PATTERN, RST_TAG_PATTERN, 32'h0000);
        run_random(25);
    endtask

    task automatic test_pattern_overlap();
        logic [31:0] start;
        start = $urandom;
        set_config(8191, 4, start, start, $urandom_range(1, 65535));
        run_random(45);
    endtask

    task automatic test_tiny_window();
        set_config(5, 0, RST_START_PATTERN, RST_TAG_PATTERN, 32'(RST_VALID_RATE_MASK));
        run_random(20);
    endtask

    // The receiver stops for a long stretch while requests keep coming, so the queue fills up.
    task automatic test_output_backpressure();
        set_config(20, 60, RST_START_PATTERN, RST_TAG_PATTERN, 32'hFFFF);
        hold_request = 1'b1;
        run_random(60);
    endtask

    // A record at the longest length, cut short by the end of the stream.
    task automatic test_longest_record();
        set_config(MAX_RECORD_BYTES, 32'(RST_SEARCH_WINDOW), RST_START_PATTERN,
                   RST_TAG_PATTERN, 32'hFFFF);
        send_byte(8'h00, 1'b1);
        send_word(RST_START_PATTERN, 1'b0);
        send_word(RST_TAG_PATTERN, 1'b0);
        repeat (40) send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b1);
    endtask

    initial begin : result_sink
        int gap;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = draw_gap(sink_calm);
            if (hold_request) begin
                hold_request = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_record_byte want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_bytes.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("unexpected record byte %h offset %0d", o_record_byte,
                             o_byte_offset);
            end else begin
                want = expected_bytes.pop_front();
                if (o_record_byte !== want.data || o_byte_offset !== want.offset ||
                    o_last_of_record !== want.last || o_truncated !== want.trunc ||
                    o_record_number !== want.number) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("mismatch: expected %h/%0d/%b/%b/%0d got %h/%0d/%b/%b/%0d",
                                 want.data, want.offset, want.last, want.trunc, want.number,
                                 o_record_byte, o_byte_offset, o_last_of_record,
                                 o_truncated, o_record_number);
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_stream_byte = '0;
        i_stream_end = 1'b0;
        reset_prediction();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_short_records();
        test_minimum_window();
        test_all_ones_start();
        test_rate_rejection();
        test_pattern_overlap();
        test_tiny_window();
        test_output_backpressure();
        test_longest_record();

        settle();
        if (expected_bytes.size() != 0) begin
            fault_count++;
            $display("%0d expected record bytes never arrived", expected_bytes.size());
        end
        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* sei_tagged_record_extractor.f */
design/ster_pkg.sv
design/ster_front.sv
design/ster_queue.sv
design/ster_back.sv
design/sei_tagged_record_extractor.sv
tb/sei_tagged_record_extractor_test.sv
